FILE: hw/rtl/urfe_pkg.sv
// ----------------------------------------------------------------------------
// urfe_pkg
// Shared types and constants for the receive ring and frame extractor.
// ----------------------------------------------------------------------------
package urfe_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned MAX_FRAME_DEF  = 64;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned FILL_W  = 9;

  localparam logic [BYTE_W-1:0] HDR_BYTE     = 8'hFF;
  localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'h7F;
  localparam logic [BYTE_W-1:0] THRESH_RESET = 8'd20;

  // Input operation codes
  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_IDLE  = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;
  localparam logic [1:0] OP_RAW   = 2'd3;

  // Commands handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_STATUS,
    CMD_FRAME,
    CMD_RAW
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [BYTE_W-1:0]   data;
    logic [LIMIT_W-1:0]  limit;
    logic                isp;
  } cmd_t;

endpackage

FILE: hw/rtl/urfe_ram.sv
// ----------------------------------------------------------------------------
// urfe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module urfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/urfe_front.sv
// ----------------------------------------------------------------------------
// urfe_front
// Accepts input items, tracks line state and the 0x7F run, and turns each
// item into a command for the back end.
// ----------------------------------------------------------------------------
module urfe_front import urfe_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         op_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic [LIMIT_W-1:0] limit_i,
  input  logic               aux_ready_i,
  input  logic               cfg_we_i,
  input  logic [BYTE_W-1:0]  cfg_wdata_i,
  output cmd_t               cmd_o
);

  logic              line_idle_q, line_idle_d;
  logic [BYTE_W-1:0] esc_run_q, esc_run_d;
  logic [BYTE_W-1:0] thr_q, thr_d;
  logic [BYTE_W-1:0] esc_inc;
  logic [LIMIT_W-1:0] lim_sat;
  logic              is_esc;

  always_comb begin
    line_idle_d = line_idle_q;
    esc_run_d   = esc_run_q;
    thr_d       = cfg_we_i ? cfg_wdata_i : thr_q;
    is_esc      = (rx_byte_i == ESC_BYTE);
    // saturate the run count
    esc_inc     = (esc_run_q == '1) ? esc_run_q : esc_run_q + 8'd1;
    lim_sat     = (limit_i > LIMIT_W'(MAX_FRAME)) ? LIMIT_W'(MAX_FRAME) : limit_i;

    cmd_o.kind  = CMD_STATUS;
    cmd_o.data  = rx_byte_i;
    cmd_o.limit = lim_sat;
    cmd_o.isp   = 1'b0;

    case (op_i)
      OP_RX: begin
        cmd_o.kind = CMD_PUSH;
        cmd_o.isp  = is_esc && (esc_inc > thr_q);
        if (accept_i) begin
          line_idle_d = 1'b0;
          esc_run_d   = is_esc ? esc_inc : '0;
        end
      end
      OP_IDLE: begin
        if (accept_i) begin
          line_idle_d = 1'b1;
        end
      end
      OP_FRAME: begin
        // busy line or aux low turns the request into a plain status
        cmd_o.kind = (line_idle_q && aux_ready_i) ? CMD_FRAME : CMD_STATUS;
      end
      OP_RAW: begin
        cmd_o.kind = CMD_RAW;
      end
      default: begin
        cmd_o.kind = CMD_STATUS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_idle_q <= 1'b1;
      esc_run_q   <= '0;
      thr_q       <= THRESH_RESET;
    end else begin
      line_idle_q <= line_idle_d;
      esc_run_q   <= esc_run_d;
      thr_q       <= thr_d;
    end
  end

endmodule

FILE: hw/rtl/urfe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// urfe_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module urfe_cmd_fifo import urfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign data_o  = slot_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

FILE: hw/rtl/urfe_back.sv
// ----------------------------------------------------------------------------
// urfe_back
// Executes commands on the byte ring: append, header search, frame and raw
// pops into a frame buffer, then replay of the buffer as results.
// ----------------------------------------------------------------------------
module urfe_back import urfe_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned MAX_FRAME  = MAX_FRAME_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              result_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              has_byte_o,
  output logic              last_o,
  output logic              dropped_o,
  output logic              isp_request_o,
  output logic [FILL_W-1:0] fill_count_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned HW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW = $clog2(MAX_FRAME + 1);
  localparam int unsigned BW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_RPLY = 2'd3;

  function automatic logic [PW-1:0] nx(input logic [PW-1:0] p);
    nx = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]         state_q, state_d;
  logic [PW-1:0]      wp_q, wp_d;
  logic [PW-1:0]      rp_q, rp_d;
  logic [HW-1:0]      held_q, held_d;
  logic               frame_q, frame_d;
  logic               synced_q, synced_d;
  logic [LIMIT_W-1:0] lim_q, lim_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      k_q, k_d;
  logic [BYTE_W-1:0]  w0_q, w0_d;

  logic               res_valid_q, res_valid_d;
  logic [BYTE_W-1:0]  res_byte_q, res_byte_d;
  logic               res_has_q, res_has_d;
  logic               res_last_q, res_last_d;
  logic               res_drop_q, res_drop_d;
  logic               res_isp_q, res_isp_d;
  logic [HW-1:0]      res_fill_q, res_fill_d;

  logic               ring_we;
  logic [PW-1:0]      ring_raddr;
  logic [BYTE_W-1:0]  ring_rdata;
  logic               buf_we;
  logic [BW-1:0]      buf_raddr;
  logic [BYTE_W-1:0]  buf_rdata;

  logic [PW-1:0]      rp_nx;
  logic               header;
  logic               pop_byte;
  logic               finish;

  urfe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wp_q),
    .wdata_i (cmd_i.data),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  urfe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME)
  ) u_frame_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (cnt_q[BW-1:0]),
    .wdata_i (w0_q),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    held_d   = held_q;
    frame_d  = frame_q;
    synced_d = synced_q;
    lim_d    = lim_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    w0_d     = w0_q;

    res_valid_d = 1'b0;
    res_byte_d  = '0;
    res_has_d   = 1'b0;
    res_last_d  = 1'b0;
    res_drop_d  = 1'b0;
    res_isp_d   = 1'b0;
    res_fill_d  = held_q;

    pop_o      = 1'b0;
    ring_we    = 1'b0;
    rp_nx      = nx(rp_q);
    ring_raddr = rp_q;
    buf_we     = 1'b0;
    buf_raddr  = '0;
    pop_byte   = 1'b0;
    finish     = 1'b0;
    // ring_rdata holds the byte after w0 while stepping
    header     = (held_q > HW'(1)) && (w0_q == HDR_BYTE) && (ring_rdata == HDR_BYTE);

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_PUSH: begin
              res_valid_d = 1'b1;
              res_last_d  = 1'b1;
              res_isp_d   = cmd_i.isp;
              if (held_q == HW'(RING_DEPTH)) begin
                res_drop_d = 1'b1;
              end else begin
                ring_we    = 1'b1;
                wp_d       = nx(wp_q);
                held_d     = held_q + 1'b1;
                res_fill_d = held_q + 1'b1;
              end
            end
            CMD_FRAME, CMD_RAW: begin
              frame_d  = (cmd_i.kind == CMD_FRAME);
              synced_d = (cmd_i.kind == CMD_RAW);
              lim_d    = cmd_i.limit;
              cnt_d    = '0;
              if (held_q == '0) begin
                if (cmd_i.kind == CMD_FRAME) begin
                  rp_d = '0;
                  wp_d = '0;
                end
                res_valid_d = 1'b1;
                res_last_d  = 1'b1;
              end else begin
                state_d = S_LOAD;
              end
            end
            default: begin
              res_valid_d = 1'b1;
              res_last_d  = 1'b1;
            end
          endcase
        end
      end

      S_LOAD: begin
        w0_d       = ring_rdata;
        ring_raddr = rp_nx;
        state_d    = S_STEP;
      end

      S_STEP: begin
        ring_raddr = rp_nx;
        if (!synced_q) begin
          // discard until FF FF
          if (held_q == '0) begin
            finish = 1'b1;
          end else if (header) begin
            synced_d = 1'b1;
          end else begin
            pop_byte = 1'b1;
          end
        end else begin
          if ((held_q == '0) || (LIMIT_W'(cnt_q) == lim_q) ||
              (frame_q && (cnt_q != '0) && header)) begin
            finish = 1'b1;
          end else begin
            pop_byte = 1'b1;
            buf_we   = 1'b1;
            cnt_d    = cnt_q + 1'b1;
          end
        end

        if (pop_byte) begin
          rp_d       = rp_nx;
          held_d     = held_q - 1'b1;
          w0_d       = ring_rdata;
          ring_raddr = nx(rp_nx);
        end

        if (finish) begin
          if (frame_q && (held_q == '0)) begin
            rp_d = '0;
            wp_d = '0;
          end
          if (cnt_q == '0) begin
            res_valid_d = 1'b1;
            res_last_d  = 1'b1;
            state_d     = S_IDLE;
          end else begin
            k_d     = '0;
            state_d = S_RPLY;
          end
        end
      end

      S_RPLY: begin
        res_valid_d = 1'b1;
        res_byte_d  = buf_rdata;
        res_has_d   = 1'b1;
        res_last_d  = (k_q == cnt_q - 1'b1);
        k_d         = k_q + 1'b1;
        buf_raddr   = k_d[BW-1:0];
        if (res_last_d) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      held_q      <= '0;
      frame_q     <= 1'b0;
      synced_q    <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      held_q      <= held_d;
      frame_q     <= frame_d;
      synced_q    <= synced_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q      <= lim_d;
    w0_q       <= w0_d;
    res_byte_q <= res_byte_d;
    res_has_q  <= res_has_d;
    res_last_q <= res_last_d;
    res_drop_q <= res_drop_d;
    res_isp_q  <= res_isp_d;
    res_fill_q <= res_fill_d;
  end

  assign result_valid_o = res_valid_q;
  assign out_byte_o     = res_byte_q;
  assign has_byte_o     = res_has_q;
  assign last_o         = res_last_q;
  assign dropped_o      = res_drop_q;
  assign isp_request_o  = res_isp_q;
  assign fill_count_o   = FILL_W'(res_fill_q);

endmodule

FILE: hw/rtl/uart_rx_ring_frame_extractor.sv
// Path: a receive byte or status item is strobed from the result register after the
//   command queue, when the back end is free.
// Frame read: load, sync to FF FF, pop to buffer, one result a cycle; raw skips sync.
// One receive byte per cycle while the back end idles; busy while two commands queue.
// Reset clears pointers, fill, escape run, threshold (20) and marks the line idle;
//   unheld ring entries are never read, so the ring is not swept.
// ----------------------------------------------------------------------------
// uart_rx_ring_frame_extractor
// Receive byte ring with FF FF header sync and frame extraction.
// ----------------------------------------------------------------------------
module uart_rx_ring_frame_extractor import urfe_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned MAX_FRAME  = MAX_FRAME_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic [LIMIT_W-1:0] limit_i,
  input  logic               aux_ready_i,
  input  logic               cfg_we_i,
  input  logic [BYTE_W-1:0]  cfg_wdata_i,
  output logic               result_valid_o,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic               has_byte_o,
  output logic               last_o,
  output logic               dropped_o,
  output logic               isp_request_o,
  output logic [FILL_W-1:0]  fill_count_o
);

  logic accept;
  logic fifo_full;
  logic fifo_empty;
  logic fifo_pop;
  cmd_t front_cmd;
  cmd_t back_cmd;

  assign accept = start && !fifo_full;
  assign busy   = fifo_full;

  urfe_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .rx_byte_i   (rx_byte_i),
    .limit_i     (limit_i),
    .aux_ready_i (aux_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (front_cmd)
  );

  urfe_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_cmd),
    .pop_i   (fifo_pop),
    .data_o  (back_cmd),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  urfe_back #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_FRAME  (MAX_FRAME)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (back_cmd),
    .empty_i        (fifo_empty),
    .pop_o          (fifo_pop),
    .result_valid_o (result_valid_o),
    .out_byte_o     (out_byte_o),
    .has_byte_o     (has_byte_o),
    .last_o         (last_o),
    .dropped_o      (dropped_o),
    .isp_request_o  (isp_request_o),
    .fill_count_o   (fill_count_o)
  );

endmodule

FILE: hw/rtl/urfe_checker.sv
// ----------------------------------------------------------------------------
// urfe_checker
// Port-level checks on the result stream of the frame extractor.
// ----------------------------------------------------------------------------
module urfe_checker import urfe_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              result_valid_o,
  input logic              has_byte_o,
  input logic              last_o,
  input logic              dropped_o,
  input logic              isp_request_o,
  input logic [FILL_W-1:0] fill_count_o
);

  // data bytes never carry receive flags
  a_byte_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && has_byte_o |-> !dropped_o && !isp_request_o)
    else $error("data result carries receive flags");

  // a status-only result always closes its item
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !has_byte_o |-> last_o)
    else $error("status result without last");

  // a frame is delivered as an unbroken burst
  a_burst_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && has_byte_o && !last_o |=> result_valid_o && has_byte_o)
    else $error("gap inside a frame transfer");

  // a dropped byte means the ring was full
  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && dropped_o |-> fill_count_o == FILL_W'(RING_DEPTH))
    else $error("byte dropped while ring not full");

endmodule

bind uart_rx_ring_frame_extractor urfe_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_urfe_checker (.*);
